// ===== rtl/mm3_pkg.sv =====
// Shared types and constants for the MurmurHash3 x86_32 key hasher.
// No dependencies; every rtl file imports this package.
package mm3_pkg;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [31:0] hash_value;
      logic [31:0] key_length;
   } rsp_type;

   // operand pair for the shared multiplier
   typedef struct packed {
      logic [31:0] op_a;
      logic [31:0] op_b;
   } mul_op_type;

   localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2  = 32'h1b873593;
   localparam logic [31:0] MIX_ADD = 32'he6546b64;
   localparam logic [31:0] MIX_X5  = 32'd5;
   localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
   localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

   localparam logic [2:0] FULL_COUNT = 3'd4;

   // register map, selected by byte address bit [2]
   localparam logic REG_SEED = 1'b0;

endpackage

// ===== rtl/murmur3_32_key_hash.sv =====
// MurmurHash3 x86_32 key hasher. Words of a key arrive one at a time on the req channel and
// one multiplier is shared by every multiply step. A full word that does not end the key goes
// through scramble multiply, second scramble multiply, fold times 5 and add before the next word
// is taken. A word that ends the key then also runs the avalanche (two multiplies, then the final
// xor-shift); a short one (0 to 3 bytes) skips the add. The seed register at byte address 0 is
// picked up when the next key starts. A finished hash waits in the rsp register; the next key may
// be taken meanwhile and only stalls at its final step if that register is still full.
module murmur3_32_key_hash (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mm3_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mm3_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import mm3_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_K2   = 3'd1;
   localparam logic [2:0] S_FOLD = 3'd2;
   localparam logic [2:0] S_ADD  = 3'd3;
   localparam logic [2:0] S_FIN1 = 3'd4;
   localparam logic [2:0] S_FIN2 = 3'd5;
   localparam logic [2:0] S_FIN3 = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [31:0] seed_ff, seed_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] total_ff, total_in;
   logic        busy_ff, busy_in;
   logic [2:0]  count_ff, count_in;
   logic        ends_ff, ends_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   mul_op_type  mul_op;
   logic [31:0] product;

   logic        accept;
   logic        csr_write;
   logic        rsp_load;
   logic [2:0]  clamp_count;
   logic [31:0] masked_word;
   logic [31:0] fold_x;
   logic [31:0] fold_rot;
   logic [31:0] fin_g;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   mm3_mul u_mul (
      .clock   (clock),
      .mul_op  (mul_op),
      .product (product)
   );

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_SEED);
   assign prdata    = (paddr[2] == REG_SEED) ? seed_ff : 32'd0;
   assign seed_in   = csr_write ? pwdata : seed_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // oversized counts act as a full word
   assign clamp_count = req_data.byte_count[2] ? FULL_COUNT : req_data.byte_count;

   always_comb begin
      case (clamp_count)
         3'd1:    masked_word = {24'd0, req_data.data_word[7:0]};
         3'd2:    masked_word = {16'd0, req_data.data_word[15:0]};
         3'd3:    masked_word = {8'd0, req_data.data_word[23:0]};
         3'd4:    masked_word = req_data.data_word;
         default: masked_word = 32'd0;
      endcase
   end

   assign fold_x   = hash_ff ^ ((count_ff != 3'd0) ? product : 32'd0);
   assign fold_rot = rotl(fold_x, 13);
   assign fin_g    = hash_ff ^ total_ff;
   assign rsp_load = (state_ff == S_FIN3) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in   = state_ff;
      hash_in    = hash_ff;
      total_in   = total_ff;
      busy_in    = busy_ff;
      count_in   = count_ff;
      ends_in    = ends_ff;
      rsp_in     = rsp_ff;
      mul_op     = '0;
      case (state_ff)
         S_IDLE: begin
            mul_op.op_a = masked_word;
            mul_op.op_b = MIX_C1;
            if (accept) begin
               count_in = clamp_count;
               ends_in  = req_data.last_word || (clamp_count != FULL_COUNT);
               if (!busy_ff) begin
                  // key start: reload seed, restart the length
                  hash_in  = seed_ff;
                  total_in = {29'd0, clamp_count};
               end else begin
                  total_in = total_ff + {29'd0, clamp_count};
               end
               state_in = S_K2;
            end
         end
         S_K2: begin
            mul_op.op_a = rotl(product, 15);
            mul_op.op_b = MIX_C2;
            state_in    = S_FOLD;
         end
         S_FOLD: begin
            mul_op.op_a = fold_rot;
            mul_op.op_b = MIX_X5;
            if (count_ff == FULL_COUNT) begin
               state_in = S_ADD;
            end else begin
               hash_in  = fold_x;
               state_in = S_FIN1;
            end
         end
         S_ADD: begin
            hash_in = product + MIX_ADD;
            if (ends_ff) begin
               state_in = S_FIN1;
            end else begin
               busy_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FIN1: begin
            mul_op.op_a = fin_g ^ (fin_g >> 16);
            mul_op.op_b = FIN_M1;
            state_in    = S_FIN2;
         end
         S_FIN2: begin
            mul_op.op_a = product ^ (product >> 13);
            mul_op.op_b = FIN_M2;
            state_in    = S_FIN3;
         end
         S_FIN3: begin
            // recirculate the product through the multiplier while the result register is full
            mul_op.op_a = product;
            mul_op.op_b = 32'd1;
            // hold until the result register is free
            if (rsp_load) begin
               rsp_in.hash_value = product ^ (product >> 16);
               rsp_in.key_length = total_ff;
               busy_in           = 1'b0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= 32'd0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= 32'd0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff  <= hash_in;
      count_ff <= count_in;
      ends_ff  <= ends_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("word taken while a word is still in work");

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_FIN3)
      else $error("result word raised outside the final step");

   a_key_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> !busy_ff && rsp_valid)
      else $error("key left open after its result");

   a_scramble_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_K2 |=> state_ff == S_FOLD)
      else $error("scramble sequence broken");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");
`endif

endmodule

// ===== rtl/mm3_mul.sv =====
// Shared 32x32 multiplier of the key hasher, low product word registered.
// Depends on mm3_pkg.
module mm3_mul (
   input  logic                   clock,
   input  mm3_pkg::mul_op_type    mul_op,
   output logic [31:0]            product
);
   import mm3_pkg::*;

   logic [31:0] product_ff;
   logic [31:0] product_in;

   assign product_in = mul_op.op_a * mul_op.op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for murmur3_32_key_hash: random and directed keys, checked against a predictor.
// Depends on mm3_pkg (request and response types) and the murmur3_32_key_hash rtl.
module tb;
   import mm3_pkg::*;

   localparam logic [31:0] SCR_M1   = 32'hcc9e2d51;
   localparam logic [31:0] SCR_M2   = 32'h1b873593;
   localparam logic [31:0] FOLD_ADD = 32'he6546b64;
   localparam logic [31:0] AVL_M1   = 32'h85ebca6b;
   localparam logic [31:0] AVL_M2   = 32'hc2b2ae35;
   localparam logic [2:0]  FULL_WORD_BYTES = 3'd4;
   localparam int SETTLE_CYCLES  = 20;
   localparam int HOLD_CYCLES    = 400;
   localparam int IDLE_LIMIT     = 4000;
   localparam int PRINT_CAP      = 40;
   localparam int PHASE_WORDS    = 220;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   murmur3_32_key_hash dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   req_type     words_pending[$];
   rsp_type     hash_expected[$];
   rsp_type     hash_want;
   int unsigned mismatch_count;
   int unsigned results_seen;
   int unsigned idle_cycles;
   logic        req_fired;
   int unsigned burst_left;
   int unsigned gap_left;
   rx_mode_type rx_mode;
   int unsigned rx_segment;
   int unsigned rx_tick;
   int unsigned hold_left;
   int unsigned holds_done;

   // predictor state
   logic [31:0] seed_model;
   logic [31:0] run_hash;
   logic [31:0] byte_sum;
   logic        key_open;

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t mismatch: %s got %08h want %08h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [31:0] scramble_word(input logic [31:0] k);
      logic [31:0] t;
      t = k * SCR_M1;
      t = {t[16:0], t[31:17]};
      return t * SCR_M2;
   endfunction

   function automatic logic [31:0] avalanche_mix(input logic [31:0] h);
      logic [31:0] t;
      t = h ^ (h >> 16);
      t = t * AVL_M1;
      t = t ^ (t >> 13);
      t = t * AVL_M2;
      return t ^ (t >> 16);
   endfunction

   // advance the predicted hash by one accepted word, queue the hash when the key ends
   task automatic hash_step(input req_type w);
      logic [2:0]  n;
      logic [31:0] k;
      logic        done;
      rsp_type     r;
      n = (w.byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : w.byte_count;
      if (!key_open) begin
         run_hash = seed_model;
         byte_sum = '0;
      end
      if (n == FULL_WORD_BYTES) begin
         run_hash = run_hash ^ scramble_word(w.data_word);
         run_hash = {run_hash[18:0], run_hash[31:19]};
         run_hash = run_hash * 32'd5 + FOLD_ADD;
         done = w.last_word;
      end else begin
         case (n)
            3'd1: k = w.data_word & 32'h000000ff;
            3'd2: k = w.data_word & 32'h0000ffff;
            3'd3: k = w.data_word & 32'h00ffffff;
            default: k = '0;
         endcase
         if (n != 3'd0)
            run_hash = run_hash ^ scramble_word(k);
         done = 1'b1;
      end
      byte_sum = byte_sum + {29'd0, n};
      if (done) begin
         r.hash_value = avalanche_mix(run_hash ^ byte_sum);
         r.key_length = byte_sum;
         hash_expected.push_back(r);
         key_open = 1'b0;
      end else begin
         key_open = 1'b1;
      end
   endtask

   // input side: note acceptance and predict
   always @(posedge clock) begin
      req_fired <= req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         hash_step(req_data);
   end

   // sender: bursts of random length, random gaps between them
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // hold the word until it is taken
      end else if (gap_left != 0) begin
         gap_left  <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (words_pending.size() != 0) begin
         req_valid <= 1'b1;
         req_data  <= words_pending.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: stall pattern of its own, plus two long hold-offs
   always @(negedge clock) begin
      rx_tick <= rx_tick + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if ((holds_done == 0 && results_seen >= 40) ||
                   (holds_done == 1 && results_seen >= 200)) begin
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
         rsp_ready  <= 1'b0;
      end else begin
         if (rx_segment == 0) begin
            rx_mode    <= rx_mode_type'($urandom_range(0, 3));
            rx_segment <= $urandom_range(20, 200);
         end else begin
            rx_segment <= rx_segment - 1;
         end
         case (rx_mode)
            RX_OPEN:     rsp_ready <= 1'b1;
            RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: rsp_ready <= rx_tick[2];
            default:     rsp_ready <= 1'b1;
         endcase
      end
   end

   // result side: compare with the oldest predicted hash
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (hash_expected.size() == 0) begin
            report_mismatch("result with none expected, hash", rsp_data.hash_value, '0);
         end else begin
            hash_want = hash_expected.pop_front();
            if (rsp_data.hash_value !== hash_want.hash_value)
               report_mismatch("hash_value", rsp_data.hash_value, hash_want.hash_value);
            if (rsp_data.key_length !== hash_want.key_length)
               report_mismatch("key_length", rsp_data.key_length, hash_want.key_length);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("** murmur3_32_key_hash: FAILED **");
         $finish;
      end
   end

   task automatic queue_word(input logic [31:0] d, input logic [2:0] c, input logic l);
      words_pending.push_back('{data_word: d, byte_count: c, last_word: l});
   endtask

   function automatic logic [31:0] pick_data();
      int unsigned sel;
      sel = $urandom_range(0, 15);
      if (sel == 0)
         return 32'h00000000;
      else if (sel == 1)
         return 32'hffffffff;
      return $urandom;
   endfunction

   // wait for the block to drain, then let its latency pass
   task automatic settle();
      do
         @(negedge clock);
      while (words_pending.size() != 0 || req_valid || hash_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write the seed, then read it back
   task automatic write_seed(input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_SEED, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      seed_model = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== value)
         report_mismatch("seed read back", prdata, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // one random key: mostly well formed, some oversized counts, some broken ends
   task automatic queue_key();
      int unsigned kind;
      int unsigned nfull;
      int unsigned tail;
      kind  = $urandom_range(0, 99);
      nfull = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
      if (kind < 80) begin
         repeat (nfull) queue_word(pick_data(), FULL_WORD_BYTES, 1'b0);
         tail = $urandom_range(0, 4);
         queue_word(pick_data(), 3'(tail), 1'b1);
      end else if (kind < 90) begin
         repeat (nfull) queue_word(pick_data(), 3'($urandom_range(4, 7)), 1'b0);
         queue_word(pick_data(), 3'($urandom_range(4, 7)), 1'b1);
      end else begin
         // short or empty word without the last flag still ends the key
         repeat (nfull) queue_word(pick_data(), FULL_WORD_BYTES, 1'b0);
         queue_word(pick_data(), 3'($urandom_range(0, 3)), 1'b0);
      end
   endtask

   initial begin
      int unsigned phase_words;
      logic [31:0] phase_seed [5];
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      mismatch_count = 0;
      results_seen   = 0;
      idle_cycles    = 0;
      req_fired      = 1'b0;
      burst_left     = 1;
      gap_left       = 0;
      rx_mode        = RX_OPEN;
      rx_segment     = 0;
      rx_tick        = 0;
      hold_left      = 0;
      holds_done     = 0;
      seed_model     = '0;
      run_hash       = '0;
      byte_sum       = '0;
      key_open       = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed keys under the reset seed
      queue_word($urandom, 3'd0, 1'b1);
      queue_word(32'hffffffff, 3'd1, 1'b1);
      queue_word(32'h00000000, 3'd2, 1'b1);
      queue_word(32'hffffffff, 3'd3, 1'b1);
      queue_word(32'hffffffff, FULL_WORD_BYTES, 1'b1);
      queue_word(32'h00000000, FULL_WORD_BYTES, 1'b0);
      queue_word($urandom, FULL_WORD_BYTES, 1'b1);
      queue_word($urandom, 3'd2, 1'b0);
      queue_word($urandom, 3'd0, 1'b0);
      queue_word($urandom, 3'd5, 1'b0);
      queue_word($urandom, 3'd6, 1'b0);
      queue_word($urandom, 3'd7, 1'b1);
      settle();

      write_seed(32'hffffffff);
      queue_word(32'hffffffff, FULL_WORD_BYTES, 1'b1);
      queue_word($urandom, FULL_WORD_BYTES, 1'b0);
      // leave the key open across a seed change; the old seed must stay in use
      settle();
      write_seed($urandom);
      queue_word($urandom, FULL_WORD_BYTES, 1'b0);
      queue_word($urandom, 3'd3, 1'b1);
      queue_word($urandom, 3'd1, 1'b1);
      settle();

      write_seed(32'h00000000);
      queue_word(32'h00000000, 3'd0, 1'b1);
      settle();

      phase_seed[0] = 32'h00000000;
      phase_seed[1] = 32'hffffffff;
      phase_seed[2] = $urandom;
      phase_seed[3] = 32'h80000001;
      phase_seed[4] = $urandom;
      foreach (phase_seed[p]) begin
         write_seed(phase_seed[p]);
         @(posedge clock);
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            queue_key();
            phase_words = words_pending.size();
         end
         settle();
      end

      if (mismatch_count == 0) begin
         $display("** murmur3_32_key_hash: PASSED **");
      end else begin
         $display("** murmur3_32_key_hash: FAILED **");
      end
      $finish;
   end

endmodule
